FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers for the plotter rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define MFPP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define MFPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/mfpp_pkg.sv
// ----------------------------------------------------------------------------
// mfpp_pkg
// shared constants and types of the monochrome frame store plotter
// ----------------------------------------------------------------------------
package mfpp_pkg;

  localparam int PANEL_WIDTH_DEF  = 152;
  localparam int PANEL_HEIGHT_DEF = 152;
  localparam int PAGE_ROWS_DEF    = 152;

  localparam int QUEUE_DEPTH = 2;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;
  localparam int IDX_W     = 12;

  // item kinds, same coding as the mode field
  localparam logic [1:0] CMD_PLOT = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // register indexes
  localparam logic REG_ROTATION    = 1'b0;
  localparam logic REG_PAGE_SELECT = 1'b1;

  localparam logic [7:0] FILL_BLACK = 8'hFF;
  localparam logic [7:0] FILL_WHITE = 8'h00;
  localparam logic [7:0] OOB_BYTE   = 8'hFF;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  typedef struct packed {
    logic [1:0] kind;
    logic       ink;
    logic       hit;
    logic [7:0] mask;
  } cmd_ctrl_t;

endpackage

FILE: rtl/core/mono_framebuffer_pixel_plotter_unit.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_plotter_unit: a taken request is registered in the front, queued, then
// run by the store back (idle, then read-modify-write) into the result register; the back takes
// no new plot or read until the last one is through; fill sweeps the store one byte a cycle
// reset clears the store the same way, no request taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mono_framebuffer_pixel_plotter_unit import mfpp_pkg::*; #(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int PAGE_ROWS    = PAGE_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // x_coord, y_coord, ink, byte_index
  input  logic [S_TUSER_W-1:0] s_tuser,   // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // read_byte, written
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_data
);

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int Q_W         = $bits(cmd_ctrl_t) + ADDR_W;

  logic              q_push;
  cmd_ctrl_t         push_ctrl;
  logic [ADDR_W-1:0] push_addr;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  logic [Q_W-1:0]    pop_data;
  logic              clearing;

  mfpp_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .PAGE_ROWS    (PAGE_ROWS),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hold      (clearing),
    .q_push    (q_push),
    .q_ctrl    (push_ctrl),
    .q_addr    (push_addr),
    .q_full    (q_full)
  );

  mfpp_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_ctrl, push_addr}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  mfpp_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd_ctrl  (pop_data[Q_W-1:ADDR_W]),
    .cmd_addr  (pop_data[ADDR_W-1:0]),
    .cmd_pop   (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .clearing  (clearing)
  );

  // requests in flight, for checking only
  logic [2:0] inflight;
  logic [2:0] inflight_next;

  assign inflight_next = inflight + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `MFPP_ASSERT_CLK(a_no_request_while_clearing, clearing |-> !s_tready, "request in clear")
  `MFPP_ASSERT_CLK(a_result_needs_request, m_tvalid |-> (inflight != 3'd0), "result without request")
  `MFPP_ASSERT_CLK(a_clear_after_reset, $fell(rst) |-> clearing, "no clear pass after reset")

endmodule

FILE: rtl/core/mfpp_front.sv
// ----------------------------------------------------------------------------
// mfpp_front
// config registers, bounds check, rotation, page rebase and byte address
// ----------------------------------------------------------------------------
module mfpp_front import mfpp_pkg::*; #(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int PAGE_ROWS    = PAGE_ROWS_DEF,
  parameter int ADDR_W       = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // x_coord, y_coord, ink, byte_index
  input  logic [S_TUSER_W-1:0]  s_tuser,   // mode
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [4:0]            cfg_data,
  input  logic                  hold,
  output logic                  q_push,
  output cmd_ctrl_t             q_ctrl,
  output logic [ADDR_W-1:0]     q_addr,
  input  logic                  q_full
);

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
  localparam int MAX_DIM  = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int XY_W     = $clog2(MAX_DIM);
  localparam int ROW_SPAN = (PANEL_HEIGHT > PAGE_ROWS) ? PANEL_HEIGHT : PAGE_ROWS;
  localparam int ROW_W    = $clog2(ROW_SPAN);
  localparam int BASE_W   = $clog2(15 * PAGE_ROWS + 1);
  localparam int DIFF_W   = ((XY_W > BASE_W) ? XY_W : BASE_W) + 1;
  localparam int PROD_W   = ROW_W + $clog2(PANEL_WIDTH + 1);
  localparam int SUM_W    = (((PROD_W > XY_W) ? PROD_W : XY_W) - 3) + 1;
  localparam int CMP_W    = (SUM_W > ADDR_W + 1) ? SUM_W : ADDR_W + 1;
  localparam int IDXX_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic signed [15:0] W_S  = 16'(PANEL_WIDTH);
  localparam logic signed [15:0] H_S  = 16'(PANEL_HEIGHT);
  localparam logic [XY_W-1:0]    W_M1 = XY_W'(PANEL_WIDTH - 1);
  localparam logic [XY_W-1:0]    H_M1 = XY_W'(PANEL_HEIGHT - 1);

  logic [1:0] rotation;
  logic [4:0] page_select;

  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [1:0]         mode;
  logic               ink;
  logic [IDX_W-1:0]   idx;
  logic [XY_W-1:0]    ux;
  logic [XY_W-1:0]    uy;
  logic [XY_W-1:0]    cx;
  logic [XY_W-1:0]    cy;
  logic               in_bounds;
  logic               paged;
  logic [BASE_W-1:0]  base;
  logic [DIFF_W-1:0]  diff;
  logic               row_ok;
  logic [ROW_W-1:0]   row;
  logic               idx_in;
  logic               hit_next;

  logic               v1;
  logic [1:0]         kind1;
  logic               ink1;
  logic               hit1;
  logic [XY_W-1:0]    cx1;
  logic [ROW_W-1:0]   row1;
  logic [IDX_W-1:0]   idx1;

  logic [PROD_W-1:0]  prod;
  logic [CMP_W-1:0]   sum;
  logic               plot_in;
  logic [IDXX_W-1:0]  idx_ext;
  logic               take;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation    <= ROT_0;
      page_select <= 5'h1F;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROTATION:    rotation    <= cfg_data[1:0];
        REG_PAGE_SELECT: page_select <= cfg_data;
        default:         rotation    <= rotation;
      endcase
    end
  end

  // stage 1: bounds, rotation, page band
  always_comb begin
    mode = s_tuser;
    px   = s_tdata[15:0];
    py   = s_tdata[31:16];
    ink  = s_tdata[32];
    idx  = s_tdata[44:33];
    in_bounds = !px[15] && !py[15] &&
                (px < (rotation[0] ? H_S : W_S)) &&
                (py < (rotation[0] ? W_S : H_S));
    ux = px[XY_W-1:0];
    uy = py[XY_W-1:0];
    unique case (rotation)
      ROT_0: begin
        cx = ux;
        cy = uy;
      end
      ROT_90: begin
        cx = W_M1 - uy;
        cy = ux;
      end
      ROT_180: begin
        cx = W_M1 - ux;
        cy = H_M1 - uy;
      end
      ROT_270: begin
        cx = uy;
        cy = H_M1 - ux;
      end
      default: begin
        cx = ux;
        cy = uy;
      end
    endcase
    paged  = !page_select[4] && (page_select != 5'd0);
    base   = BASE_W'(page_select[3:0]) * BASE_W'(PAGE_ROWS);
    diff   = DIFF_W'(cy) - DIFF_W'(base);
    row_ok = !paged || (!diff[DIFF_W-1] && (diff < DIFF_W'(PAGE_ROWS)));
    row    = paged ? ROW_W'(diff) : ROW_W'(cy);
    idx_in = 32'(idx) < 32'(STORE_BYTES);
    priority if (mode == CMD_PLOT) hit_next = in_bounds && row_ok;
    else if (mode == CMD_READ)     hit_next = idx_in;
    else                           hit_next = 1'b0;
  end

  assign take     = q_push;
  assign q_push   = v1 && !q_full;
  assign s_tready = !hold && (!v1 || !q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      v1 <= 1'b1;
    end else if (take) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind1 <= mode;
      ink1  <= ink;
      hit1  <= hit_next;
      cx1   <= cx;
      row1  <= row;
      idx1  <= idx;
    end
  end

  // stage 2: byte address and bit mask
  always_comb begin
    prod    = PROD_W'(row1) * PROD_W'(PANEL_WIDTH);
    sum     = CMP_W'(prod >> 3) + CMP_W'(cx1 >> 3);
    plot_in = sum < CMP_W'(STORE_BYTES);
    idx_ext = IDXX_W'(idx1);
    q_ctrl.kind = kind1;
    q_ctrl.ink  = ink1;
    q_ctrl.hit  = hit1 && ((kind1 != CMD_PLOT) || plot_in);
    q_ctrl.mask = 8'h80 >> cx1[2:0];
    q_addr = (kind1 == CMD_READ) ? idx_ext[ADDR_W-1:0] : sum[ADDR_W-1:0];
  end

endmodule

FILE: rtl/core/mfpp_queue.sv
// ----------------------------------------------------------------------------
// mfpp_queue
// short command queue between address front and store back
// ----------------------------------------------------------------------------
module mfpp_queue import mfpp_pkg::*; #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/mfpp_back.sv
// ----------------------------------------------------------------------------
// mfpp_back
// frame store memory, read-modify-write, fill and clear sweeps, result reg
// ----------------------------------------------------------------------------
module mfpp_back import mfpp_pkg::*; #(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int ADDR_W       = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  cmd_ctrl_t            cmd_ctrl,
  input  logic [ADDR_W-1:0]    cmd_addr,
  output logic                 cmd_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // read_byte, written
  output logic                 clearing
);

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [7:0]        mem [STORE_BYTES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        rdata;

  logic [1:0]        state;
  logic [ADDR_W-1:0] cnt;
  logic [7:0]        sweep_val;
  logic              sweep_res;
  cmd_ctrl_t         cur;
  logic [ADDR_W-1:0] cur_addr;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_wr;
  logic              out_free;
  logic              last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[cmd_addr];
  end

  assign out_free = !out_valid || m_tready;
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid && out_free;
  assign last     = cnt == ADDR_W'(STORE_BYTES - 1);
  assign clearing = (state == ST_SWEEP) && !sweep_res;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W - 9){1'b0}}, out_wr, out_byte};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = cur.ink ? (rdata & ~cur.mask) : (rdata | cur.mask);
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = cnt;
      mem_wdata = sweep_val;
    end else if ((state == ST_EXEC) && (cur.kind == CMD_PLOT) && cur.hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      cnt       <= '0;
      sweep_val <= FILL_WHITE;
      sweep_res <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          if (!last) begin
            cnt <= cnt + 1'b1;
          end else if (!sweep_res) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            out_byte  <= ZERO_BYTE;
            out_wr    <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd_ctrl.kind == CMD_FILL) begin
              state     <= ST_SWEEP;
              cnt       <= '0;
              sweep_val <= cmd_ctrl.ink ? FILL_WHITE : FILL_BLACK;
              sweep_res <= 1'b1;
            end else begin
              state    <= ST_EXEC;
              cur      <= cmd_ctrl;
              cur_addr <= cmd_addr;
            end
          end
        end
        ST_EXEC: begin
          state     <= ST_IDLE;
          out_valid <= 1'b1;
          out_wr    <= (cur.kind == CMD_PLOT) && cur.hit;
          if (cur.kind == CMD_READ) begin
            out_byte <= cur.hit ? ~rdata : OOB_BYTE;
          end else begin
            out_byte <= ZERO_BYTE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the monochrome frame store plotter against a shadow copy of the
// store kept here: plots, fills, reads and no-ops under every rotation and
// several page settings, a directed pass over the corner cases, then random traffic
// with random gaps on the request side and random stalls on the result side
// ----------------------------------------------------------------------------
module tb;
  import mfpp_pkg::*;

  localparam int PANEL_W      = PANEL_WIDTH_DEF;
  localparam int PANEL_H      = PANEL_HEIGHT_DEF;
  localparam int PAGE_H       = PAGE_ROWS_DEF;
  localparam int STORE_BYTES  = PANEL_W * PANEL_H / 8;
  localparam int IDLE_LIMIT   = 12000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1000;
  localparam logic INK_BLACK  = 1'b0;
  localparam logic INK_WHITE  = 1'b1;

  typedef struct {
    logic [1:0]         mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               ink;
    logic [11:0]        idx;
  } pixel_req_t;

  typedef struct {
    logic [7:0] read_byte;
    logic       written;
  } pixel_resp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // x_coord, y_coord, ink, byte_index
  logic [S_TUSER_W-1:0] s_tuser = '0;   // mode
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;        // read_byte, written
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = 1'b0;
  logic [4:0]           cfg_data = '0;

  logic [7:0]         shadow_frame [STORE_BYTES];
  logic [1:0]         shadow_rotation;
  logic signed [4:0]  shadow_page;
  int                 last_plot_addr = 0;
  pixel_resp_t        pending_results [$];
  int                 mismatch_count = 0;
  int                 stalled_cycles = 0;
  int                 ready_left = 0;
  bit                 idle_on = 1'b1;
  bit                 stall_on = 1'b1;

  mono_framebuffer_pixel_plotter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow store
  function automatic logic plot_pixel(input int px, input int py, input logic ink);
    int wr;
    int hr;
    int cx;
    int cy;
    int addr;
    logic [7:0] mask;
    wr = shadow_rotation[0] ? PANEL_H : PANEL_W;
    hr = shadow_rotation[0] ? PANEL_W : PANEL_H;
    if (px < 0 || px >= wr || py < 0 || py >= hr) return 1'b0;
    case (shadow_rotation)
      2'd1: begin
        cx = PANEL_W - py - 1;
        cy = px;
      end
      2'd2: begin
        cx = PANEL_W - px - 1;
        cy = PANEL_H - py - 1;
      end
      2'd3: begin
        cx = py;
        cy = PANEL_H - px - 1;
      end
      default: begin
        cx = px;
        cy = py;
      end
    endcase
    if (shadow_page >= 1) begin
      cy = cy - int'(shadow_page) * PAGE_H;
      if (cy < 0 || cy >= PAGE_H) return 1'b0;
    end
    addr = cx / 8 + (cy * PANEL_W) / 8;
    if (addr >= STORE_BYTES) return 1'b0;
    mask = 8'h80 >> (cx % 8);
    if (ink == INK_BLACK) shadow_frame[addr] = shadow_frame[addr] | mask;
    else shadow_frame[addr] = shadow_frame[addr] & ~mask;
    last_plot_addr = addr;
    return 1'b1;
  endfunction

  function automatic pixel_resp_t predict_response(input pixel_req_t req);
    pixel_resp_t resp;
    resp.read_byte = ZERO_BYTE;
    resp.written   = 1'b0;
    case (req.mode)
      CMD_PLOT: resp.written = plot_pixel(req.x, req.y, req.ink);
      CMD_FILL: begin
        foreach (shadow_frame[i])
          shadow_frame[i] = (req.ink == INK_BLACK) ? FILL_BLACK : FILL_WHITE;
        resp.written = 1'b1;
      end
      CMD_READ: resp.read_byte = (req.idx < STORE_BYTES) ? ~shadow_frame[req.idx] : OOB_BYTE;
      default: ;
    endcase
    return resp;
  endfunction

  function automatic pixel_req_t make_request(input logic [1:0] mode, input int x,
                                              input int y, input logic ink, input int idx);
    pixel_req_t req;
    req.mode = mode;
    req.x    = x[15:0];
    req.y    = y[15:0];
    req.ink  = ink;
    req.idx  = idx[11:0];
    return req;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request side
  task automatic send_request(input pixel_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.mode;
    s_tdata  <= {3'b000, req.idx, req.ink, req.y, req.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_response(req));
  endtask

  task automatic write_register(input logic index, input logic [4:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (index == REG_ROTATION) shadow_rotation = value[1:0];
    else shadow_page = value;
  endtask

  // result side
  always @(posedge clk) begin : sink_pacing
    int r;
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (!stall_on || $urandom_range(0, 1) == 0) begin
      m_tready   <= 1'b1;
      ready_left <= $urandom_range(0, 6);
    end else begin
      r = $urandom_range(0, 99);
      m_tready   <= 1'b0;
      ready_left <= (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
  end

  always @(posedge clk) begin : result_check
    pixel_resp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending request: read_byte %h written %b",
               m_tdata[7:0], m_tdata[8]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.read_byte) begin
          $error("read_byte expected %h got %h", want.read_byte, m_tdata[7:0]);
          mismatch_count++;
        end
        if (m_tdata[8] !== want.written) begin
          $error("written expected %b got %b", want.written, m_tdata[8]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // tests
  task automatic test_reset_state();
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, 0));
    send_request(make_request(CMD_READ, -1, -1, INK_WHITE, 4095));
  endtask

  task automatic test_plot_bounds();
    send_request(make_request(CMD_PLOT, 0, 0, INK_BLACK, 0));
    send_request(make_request(CMD_PLOT, PANEL_W - 1, PANEL_H - 1, INK_BLACK, 0));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, 0));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, STORE_BYTES - 1));
    send_request(make_request(CMD_PLOT, -1, 0, INK_BLACK, 0));
    send_request(make_request(CMD_PLOT, 0, PANEL_H, INK_BLACK, 0));
    send_request(make_request(CMD_PLOT, -32768, 32767, INK_BLACK, 0));
    send_request(make_request(CMD_PLOT, 32767, -32768, INK_BLACK, 0));
    send_request(make_request(CMD_PLOT, PANEL_W - 1, PANEL_H - 1, INK_WHITE, 0));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, STORE_BYTES - 1));
    send_request(make_request(CMD_NOP, -1, -1, INK_WHITE, 4095));
  endtask

  task automatic test_rotations();
    for (int rot = 1; rot < 4; rot++) begin
      write_register(REG_ROTATION, 5'(rot));
      send_request(make_request(CMD_PLOT, 0, 0, INK_BLACK, 0));
    end
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, PANEL_W / 8 - 1));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, STORE_BYTES - 1));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, STORE_BYTES - PANEL_W / 8));
    write_register(REG_ROTATION, 5'd0);
  endtask

  task automatic test_paging();
    write_register(REG_PAGE_SELECT, 5'd1);
    send_request(make_request(CMD_PLOT, 3, 3, INK_BLACK, 0));
    write_register(REG_PAGE_SELECT, 5'd15);
    send_request(make_request(CMD_PLOT, 0, 0, INK_WHITE, 0));
    send_request(make_request(CMD_FILL, 0, 0, INK_BLACK, 0));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, 100));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, STORE_BYTES));
    write_register(REG_PAGE_SELECT, 5'b10000);
    send_request(make_request(CMD_PLOT, 7, 7, INK_WHITE, 0));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, 7 * PANEL_W / 8));
    write_register(REG_PAGE_SELECT, 5'd0);
    send_request(make_request(CMD_FILL, 0, 0, INK_WHITE, 0));
    send_request(make_request(CMD_READ, 0, 0, INK_BLACK, 7 * PANEL_W / 8));
    write_register(REG_PAGE_SELECT, 5'b11111);
  endtask

  function automatic pixel_req_t random_request();
    pixel_req_t req;
    int r;
    r = $urandom_range(0, 99);
    req.x    = 16'($urandom);
    req.y    = 16'($urandom);
    req.ink  = 1'($urandom_range(0, 1));
    req.idx  = 12'($urandom);
    req.mode = CMD_NOP;
    if (r < 50) begin
      req.mode = CMD_PLOT;
      if ($urandom_range(0, 9) < 8) begin
        req.x = 16'($urandom_range(0, PANEL_W - 1));
        req.y = 16'($urandom_range(0, PANEL_H - 1));
      end else if ($urandom_range(0, 1) == 0) begin
        req.x = 16'($urandom_range(0, PANEL_W + 3) - 2);
        req.y = 16'($urandom_range(0, PANEL_H + 3) - 2);
      end
    end else if (r < 85) begin
      req.mode = CMD_READ;
      r = $urandom_range(0, 9);
      if (r < 6) req.idx = 12'(last_plot_addr);
      else if (r < 9) req.idx = 12'($urandom_range(0, STORE_BYTES - 1));
    end else if (r < 87) begin
      req.mode = CMD_FILL;
    end else if (r >= 92) begin
      case ($urandom_range(0, 2))
        0:       req.mode = CMD_PLOT;
        1:       req.mode = CMD_READ;
        default: req.mode = CMD_NOP;
      endcase
    end
    return req;
  endfunction

  task automatic test_random_traffic();
    int r;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 125 == 0) begin
        write_register(REG_ROTATION, 5'($urandom_range(0, 3)));
        r = $urandom_range(0, 9);
        if (r < 6) write_register(REG_PAGE_SELECT, $urandom_range(0, 1) ? 5'b11111 : 5'd0);
        else if (r < 9) write_register(REG_PAGE_SELECT, 5'($urandom_range(1, 15)));
        else write_register(REG_PAGE_SELECT, 5'($urandom_range(16, 31)));
      end
      if (n % 64 == 0) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      send_request(random_request());
    end
  endtask

  task automatic finish_run();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  endtask

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    shadow_rotation = 2'd0;
    shadow_page     = -5'sd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_plot_bounds();
    test_rotations();
    test_paging();
    test_random_traffic();
    finish_run();
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mfpp_pkg.sv
rtl/core/mfpp_front.sv
rtl/core/mfpp_queue.sv
rtl/core/mfpp_back.sv
rtl/core/mono_framebuffer_pixel_plotter_unit.sv
tb/sv/tb.sv
